// ===== design/sic_pkg.sv =====
// Shared types and constants for the segment intersection classifier.
package sic_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FIELD_BITS     = 32;
    localparam int NUM_FIELDS     = 8;
    localparam int IN_DATA_BITS   = FIELD_BITS * NUM_FIELDS;
    localparam int OUT_DATA_BITS  = 8;

    typedef enum logic [1:0] {
        REL_APART = 2'd0,
        REL_TOUCH = 2'd1,
        REL_CROSS = 2'd2
    } relation_t;

    // Sign of a cross product: nonzero flag and negative flag.
    typedef struct packed {
        logic nz;
        logic neg;
    } sign_t;

    // Load enables of the multiply and subtract stages.
    typedef struct packed {
        logic en2;
        logic en3;
    } stage_en_t;

endpackage

// ===== design/segment_intersection_classifier.sv =====
// Segment intersection classifier: four-stage pipeline over exact integer cross products.
// Four register stages (difference, multiply, subtract/sign, classify), the first one
//   loaded at accept and the last one driving output valid.
// Throughput: one segment pair per cycle; each stage holds under back-pressure
//   and empty stages fill while later ones wait.
// Reset: rst_n clears every stage valid bit at once; data registers are not reset.
module segment_intersection_classifier #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y (32 bits each)
    input  logic [sic_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // relation [1:0], zero fill [7:2]
    output logic [sic_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
    import sic_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 1;

    // stage control
    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      en1, en2, en3, en4;
    stage_en_t cross_en;

    // input coordinates
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;

    // stage 1
    logic signed [CW-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg, dx_reg, dy_reg;
    logic signed [DW-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [DW-1:0] cax_reg, cay_reg, dax_reg, day_reg;
    logic signed [DW-1:0] acx_reg, acy_reg, bcx_reg, bcy_reg;

    // stage 2
    logic [DW-1:0]        mag_x, mag_y;
    logic                 use_x;
    logic signed [CW-1:0] u1_reg, u2_reg, w1_reg, w2_reg;

    // stage 3
    logic signed [CW-1:0] lo1_reg, hi1_reg, lo2_reg, hi2_reg;
    sign_t                s_par, s2a, s2b, s1a, s1b;

    // stage 4
    relation_t            relation_next;
    relation_t            relation_reg;
    logic                 p2_pos, p2_neg, p1_pos, p1_neg;

    assign en4 = !v4_reg || m_axis_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign cross_en.en2 = en2;
    assign cross_en.en3 = en3;

    assign s_axis_tready = en1;
    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-2){1'b0}}, relation_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Only the low COORD_BITS of each field count as the coordinate.
    assign ax = s_axis_tdata[0*FIELD_BITS +: CW];
    assign ay = s_axis_tdata[1*FIELD_BITS +: CW];
    assign bx = s_axis_tdata[2*FIELD_BITS +: CW];
    assign by = s_axis_tdata[3*FIELD_BITS +: CW];
    assign cx = s_axis_tdata[4*FIELD_BITS +: CW];
    assign cy = s_axis_tdata[5*FIELD_BITS +: CW];
    assign dx = s_axis_tdata[6*FIELD_BITS +: CW];
    assign dy = s_axis_tdata[7*FIELD_BITS +: CW];

    // stage 1: edge vectors and point offsets
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ax_reg  <= ax;
            ay_reg  <= ay;
            bx_reg  <= bx;
            by_reg  <= by;
            cx_reg  <= cx;
            cy_reg  <= cy;
            dx_reg  <= dx;
            dy_reg  <= dy;
            e1x_reg <= DW'(bx) - DW'(ax);
            e1y_reg <= DW'(by) - DW'(ay);
            e2x_reg <= DW'(dx) - DW'(cx);
            e2y_reg <= DW'(dy) - DW'(cy);
            cax_reg <= DW'(cx) - DW'(ax);
            cay_reg <= DW'(cy) - DW'(ay);
            dax_reg <= DW'(dx) - DW'(ax);
            day_reg <= DW'(dy) - DW'(ay);
            acx_reg <= DW'(ax) - DW'(cx);
            acy_reg <= DW'(ay) - DW'(cy);
            bcx_reg <= DW'(bx) - DW'(cx);
            bcy_reg <= DW'(by) - DW'(cy);
        end
    end

    // stages 2 and 3: cross product signs
    sic_cross #(.DW(DW)) u_cross_par (
        .clk(clk), .en(cross_en),
        .ax(e1x_reg), .ay(e1y_reg), .bx(e2x_reg), .by(e2y_reg),
        .sign(s_par)
    );

    sic_cross #(.DW(DW)) u_cross_s2a (
        .clk(clk), .en(cross_en),
        .ax(e1x_reg), .ay(e1y_reg), .bx(cax_reg), .by(cay_reg),
        .sign(s2a)
    );

    sic_cross #(.DW(DW)) u_cross_s2b (
        .clk(clk), .en(cross_en),
        .ax(e1x_reg), .ay(e1y_reg), .bx(dax_reg), .by(day_reg),
        .sign(s2b)
    );

    sic_cross #(.DW(DW)) u_cross_s1a (
        .clk(clk), .en(cross_en),
        .ax(e2x_reg), .ay(e2y_reg), .bx(acx_reg), .by(acy_reg),
        .sign(s1a)
    );

    sic_cross #(.DW(DW)) u_cross_s1b (
        .clk(clk), .en(cross_en),
        .ax(e2x_reg), .ay(e2y_reg), .bx(bcx_reg), .by(bcy_reg),
        .sign(s1b)
    );

    // stage 2: pick the projection axis from the first segment's larger extent
    assign mag_x = e1x_reg[DW-1] ? DW'(-e1x_reg) : DW'(e1x_reg);
    assign mag_y = e1y_reg[DW-1] ? DW'(-e1y_reg) : DW'(e1y_reg);
    assign use_x = mag_x > mag_y;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            u1_reg <= use_x ? ax_reg : ay_reg;
            u2_reg <= use_x ? bx_reg : by_reg;
            w1_reg <= use_x ? cx_reg : cy_reg;
            w2_reg <= use_x ? dx_reg : dy_reg;
        end
    end

    // stage 3: order the interval ends
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            lo1_reg <= (u1_reg < u2_reg) ? u1_reg : u2_reg;
            hi1_reg <= (u1_reg < u2_reg) ? u2_reg : u1_reg;
            lo2_reg <= (w1_reg < w2_reg) ? w1_reg : w2_reg;
            hi2_reg <= (w1_reg < w2_reg) ? w2_reg : w1_reg;
        end
    end

    // stage 4: classify
    assign p2_pos = s2a.nz && s2b.nz && (s2a.neg == s2b.neg);
    assign p2_neg = s2a.nz && s2b.nz && (s2a.neg != s2b.neg);
    assign p1_pos = s1a.nz && s1b.nz && (s1a.neg == s1b.neg);
    assign p1_neg = s1a.nz && s1b.nz && (s1a.neg != s1b.neg);

    always_comb
    begin
        relation_next = REL_TOUCH;
        if (!s_par.nz)
        begin
            if (s2a.nz)
                relation_next = REL_APART;
            else if ((lo2_reg > hi1_reg) || (lo1_reg > hi2_reg))
                relation_next = REL_APART;
            else if ((lo2_reg == hi1_reg) || (lo1_reg == hi2_reg))
                relation_next = REL_TOUCH;
            else
                relation_next = REL_CROSS;
        end
        else
        begin
            if (p2_pos || p1_pos)
                relation_next = REL_APART;
            else if (p2_neg && p1_neg)
                relation_next = REL_CROSS;
            else
                relation_next = REL_TOUCH;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            relation_reg <= relation_next;
        end
    end

    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted item missing from stage 1");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !m_axis_tready))
        else $error("input stalled while pipeline has room");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |=> v1_reg)
        else $error("stage 1 item lost under stall");

    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en4) |=> v3_reg)
        else $error("stage 3 item lost under stall");

    a_no_code3: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("relation code out of range");

endmodule

// ===== design/sic_cross.sv =====
// Two-stage cross product sign unit: multiply stage, then subtract and sign stage.
module sic_cross #(
    parameter int DW = sic_pkg::COORD_BITS_DEF + 1
) (
    input  logic                   clk,
    input  sic_pkg::stage_en_t     en,
    input  logic signed [DW-1:0]   ax,
    input  logic signed [DW-1:0]   ay,
    input  logic signed [DW-1:0]   bx,
    input  logic signed [DW-1:0]   by,
    output sic_pkg::sign_t         sign
);
    import sic_pkg::*;

    localparam int PW = 2 * DW;

    logic signed [PW-1:0] p_axby_reg;
    logic signed [PW-1:0] p_aybx_reg;
    logic        [PW:0]   diff;
    sign_t                sign_reg;
    sign_t                sign_next;

    always_ff @(posedge clk)
    begin
        if (en.en2)
        begin
            p_axby_reg <= ax * by;
            p_aybx_reg <= ay * bx;
        end
    end

    // Widen by one bit so the difference of two full products cannot wrap.
    assign diff = {p_axby_reg[PW-1], p_axby_reg} - {p_aybx_reg[PW-1], p_aybx_reg};

    always_comb
    begin
        sign_next.nz  = |diff;
        sign_next.neg = diff[PW];
    end

    always_ff @(posedge clk)
    begin
        if (en.en3)
        begin
            sign_reg <= sign_next;
        end
    end

    assign sign = sign_reg;

endmodule

// ===== verif/sic_relation_checker.sv =====
// Scoreboard for the segment intersection classifier: predicts each relation and compares.
module sic_relation_checker #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [sic_pkg::IN_DATA_BITS-1:0]  in_data,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [sic_pkg::OUT_DATA_BITS-1:0] out_data,
    output int                                mismatches,
    output int                                outstanding
);
    import sic_pkg::*;

    relation_t expected_relations[$];
    int        fail_total = 0;
    int        queued     = 0;

    assign mismatches  = fail_total;
    assign outstanding = queued;

    // Coordinate is the sign extension of the low COORD_BITS bits of the field.
    function automatic longint coordinate(input logic [IN_DATA_BITS-1:0] data,
                                          input int idx);
        logic [FIELD_BITS-1:0] raw;
        longint                v;
        raw = data[idx*FIELD_BITS +: FIELD_BITS];
        v   = longint'({32'b0, raw});
        v   = (v << (64 - COORD_BITS)) >>> (64 - COORD_BITS);
        return v;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Sign of ax*by - ay*bx, exact.
    function automatic int cross_sign(input longint ax, input longint ay,
                                      input longint bx, input longint by);
        logic signed [129:0] wax, way, wbx, wby, d;
        wax = ax;
        way = ay;
        wbx = bx;
        wby = by;
        d   = wax * wby - way * wbx;
        if (d < 0)
            return -1;
        return (d != 0) ? 1 : 0;
    endfunction

    // Side of point r relative to the directed line p->q.
    function automatic int side_of(input longint px, input longint py,
                                   input longint qx, input longint qy,
                                   input longint rx, input longint ry);
        return cross_sign(qx - px, qy - py, rx - px, ry - py);
    endfunction

    function automatic relation_t classify_segments(input logic [IN_DATA_BITS-1:0] data);
        longint    ax, ay, bx, by, cx, cy, dx, dy;
        longint    u1, u2, v1, v2, lo1, hi1, lo2, hi2;
        logic      use_x;
        int        s2a, s2b, s1a, s1b, p1, p2;
        relation_t rel;
        ax = coordinate(data, 0);
        ay = coordinate(data, 1);
        bx = coordinate(data, 2);
        by = coordinate(data, 3);
        cx = coordinate(data, 4);
        cy = coordinate(data, 5);
        dx = coordinate(data, 6);
        dy = coordinate(data, 7);
        if (cross_sign(bx - ax, by - ay, dx - cx, dy - cy) == 0)
        begin
            if (side_of(ax, ay, bx, by, cx, cy) != 0)
            begin
                rel = REL_APART;
            end
            else
            begin
                // project onto the axis along which the first segment changes most
                use_x = magnitude(bx - ax) > magnitude(by - ay);
                u1  = use_x ? ax : ay;
                u2  = use_x ? bx : by;
                v1  = use_x ? cx : cy;
                v2  = use_x ? dx : dy;
                lo1 = (u1 < u2) ? u1 : u2;
                hi1 = (u1 < u2) ? u2 : u1;
                lo2 = (v1 < v2) ? v1 : v2;
                hi2 = (v1 < v2) ? v2 : v1;
                if (lo2 > hi1 || lo1 > hi2)
                    rel = REL_APART;
                else if (lo2 == hi1 || lo1 == hi2)
                    rel = REL_TOUCH;
                else
                    rel = REL_CROSS;
            end
        end
        else
        begin
            s2a = side_of(ax, ay, bx, by, cx, cy);
            s2b = side_of(ax, ay, bx, by, dx, dy);
            s1a = side_of(cx, cy, dx, dy, ax, ay);
            s1b = side_of(cx, cy, dx, dy, bx, by);
            p2  = s2a * s2b;
            p1  = s1a * s1b;
            if (p2 > 0 || p1 > 0)
                rel = REL_APART;
            else if (p2 < 0 && p1 < 0)
                rel = REL_CROSS;
            else
                rel = REL_TOUCH;
        end
        return rel;
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_total < 100)
            $display("[%0t] mismatch: %s", $time, what);
        fail_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        relation_t want;
        if (!rst_n)
        begin
            expected_relations.delete();
            queued = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_relations.push_back(classify_segments(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_relations.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item, relation %0d",
                                              out_data[1:0]));
                end
                else
                begin
                    want = expected_relations.pop_front();
                    if (out_data[1:0] != want)
                        report_mismatch($sformatf("relation %0d, expected %0d",
                                                  out_data[1:0], want));
                    if (out_data[OUT_DATA_BITS-1:2] != '0)
                        report_mismatch($sformatf("fill bits 0x%0h not zero",
                                                  out_data[OUT_DATA_BITS-1:2]));
                end
            end
            queued = expected_relations.size();
        end
    end

endmodule

// ===== verif/segment_intersection_classifier_tb.sv =====
// Testbench top for the segment intersection classifier: stimulus, flow control and verdict.
module segment_intersection_classifier_tb;
    import sic_pkg::*;

    localparam int     ITEM_COUNT = 1050;
    localparam longint RUN_LIMIT  = 2_000_000;
    localparam int     MAX_C      = 32'h7fff_ffff;
    localparam int     MIN_C      = 32'h8000_0000;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     steady = 1'b0;
    int                       mismatches;
    int                       outstanding;

    segment_intersection_classifier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sic_relation_checker relation_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_data     (s_axis_tdata),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [IN_DATA_BITS-1:0] pack_segments(
        input int ax, ay, bx, by, cx, cy, dx, dy);
        return {dy, dx, cy, cx, by, bx, ay, ax};
    endfunction

    function automatic int pick_in(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 5))
            0:       return MAX_C;
            1:       return MIN_C;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IN_DATA_BITS-1:0] random_pair();
        int c[8];
        int ox, oy, px, py, k;
        for (int i = 0; i < 8; i++)
            c[i] = 0;
        case ($urandom_range(0, 9))
            0, 1: begin
                for (int i = 0; i < 8; i++)
                    c[i] = $urandom;
            end
            2, 3: begin
                for (int i = 0; i < 8; i++)
                    c[i] = pick_in(-8, 8);
            end
            4, 5: begin
                // four points on one line
                ox = pick_in(-(1 << 24), 1 << 24);
                oy = pick_in(-(1 << 24), 1 << 24);
                px = pick_in(-6, 6);
                py = pick_in(-6, 6);
                for (int i = 0; i < 4; i++) begin
                    k = pick_in(-8, 8);
                    c[2*i]   = ox + k * px;
                    c[2*i+1] = oy + k * py;
                end
            end
            6: begin
                // second segment starts or ends on an endpoint of the first
                for (int i = 0; i < 8; i++)
                    c[i] = pick_in(-100, 100);
                k = $urandom_range(0, 1) * 2;
                if ($urandom_range(0, 1)) begin
                    c[4] = c[k];
                    c[5] = c[k+1];
                end
                else begin
                    c[6] = c[k];
                    c[7] = c[k+1];
                end
            end
            7: begin
                // parallel copy, shifted
                for (int i = 0; i < 4; i++)
                    c[i] = pick_in(-50, 50);
                ox = pick_in(-3, 3);
                oy = pick_in(-3, 3);
                c[4] = c[0] + ox;
                c[5] = c[1] + oy;
                c[6] = c[2] + ox;
                c[7] = c[3] + oy;
            end
            8: begin
                for (int i = 0; i < 8; i++)
                    c[i] = extreme_coord();
            end
            default: begin
                for (int i = 0; i < 8; i++)
                    c[i] = pick_in(-32768, 32767);
            end
        endcase
        return pack_segments(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endfunction

    // Call at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_pair(input logic [IN_DATA_BITS-1:0] pair);
        while (!steady && $urandom_range(0, 99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pair;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_directed();
        send_pair(pack_segments(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(pack_segments(0, 0, 10, 0, 5, 0, 5, 10));
        send_pair(pack_segments(0, 0, 1, 1, 5, 0, 6, -3));
        send_pair(pack_segments(0, 0, 4, 4, 4, 4, 8, 0));
        send_pair(pack_segments(0, 0, 10, 0, 0, 1, 10, 1));
        send_pair(pack_segments(0, 0, 10, 0, 5, 0, 15, 0));
        send_pair(pack_segments(0, 0, 10, 0, 10, 0, 20, 0));
        send_pair(pack_segments(0, 0, 10, 0, 11, 0, 20, 0));
        send_pair(pack_segments(3, 0, 3, 10, 3, -5, 3, 2));
        send_pair(pack_segments(0, 0, 5, 5, -5, -5, 0, 0));
        send_pair(pack_segments(10, 0, 0, 0, -3, 0, 30, 0));
        send_pair(pack_segments(0, 0, 10, 0, 5, 1, 5, 10));
        // zero-length segments
        send_pair(pack_segments(2, 2, 2, 2, 0, 0, 4, 4));
        send_pair(pack_segments(2, 3, 2, 3, 0, 0, 4, 4));
        send_pair(pack_segments(0, 0, 4, 4, 2, 2, 2, 2));
        send_pair(pack_segments(1, 1, 1, 1, 1, 1, 1, 1));
        send_pair(pack_segments(1, 1, 1, 1, 2, 2, 2, 2));
        // coordinate extremes
        send_pair(pack_segments(MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MAX_C, MAX_C, MIN_C));
        send_pair(pack_segments(MIN_C, MIN_C, MAX_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C));
        send_pair(pack_segments(MAX_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C));
        send_pair(pack_segments(MIN_C, 0, MAX_C, 0, 0, 0, 0, MAX_C));
        send_pair(pack_segments(MIN_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C, MIN_C));
        send_pair('0);
        send_pair('1);
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        for (int n = 0; n < ITEM_COUNT; n++) begin
            // no idling on either side through this stretch
            steady = (n >= 400 && n < 600);
            send_pair(random_pair());
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("segment_intersection_classifier test passed");
        else
            $display("segment_intersection_classifier test failed");
        $finish;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 32);
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("segment_intersection_classifier test failed");
        $finish;
    end

endmodule
